@@ hdl/cdpc_pkg.sv @@
package cdpc_pkg;

   // Deck geometry.
   localparam int CARDS_IN_DECK = 52;
   localparam int RANK_COUNT    = 13;
   localparam int SUIT_COUNT    = 4;
   localparam int RANK_W        = 4;
   localparam int SUIT_W        = 2;
   localparam int NUMBER_W      = 6;
   localparam int COUNT_W       = 6;
   localparam int STATUS_W      = 3;
   localparam int ERROR_W       = 2;

   // Card count saturates here and never wraps.
   localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;
   localparam logic [NUMBER_W-1:0] NO_CARD   = NUMBER_W'(CARDS_IN_DECK);

   // Held error codes.
   localparam logic [ERROR_W-1:0] ERR_NONE    = 2'd0;
   localparam logic [ERROR_W-1:0] ERR_INVALID = 2'd1;
   localparam logic [ERROR_W-1:0] ERR_DUP     = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUP         = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DECK_VALID  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_WRONG_COUNT = 3'd4;

   typedef logic [RANK_W-1:0]     rank_type;
   typedef logic [SUIT_W-1:0]     suit_type;
   typedef logic [RANK_COUNT-1:0] row_type;

   // One decoded card: ok is low when either character is not in its list.
   typedef struct packed {
      logic     ok;
      rank_type rank;
      suit_type suit;
   } card_type;

   // Card number suit*13 + rank, built from shifts.
   function automatic logic [NUMBER_W-1:0] deck_pos(input suit_type s, input rank_type r);
      logic [NUMBER_W-1:0] s13;
      s13 = NUMBER_W'({s, 3'b000}) + NUMBER_W'({s, 2'b00}) + NUMBER_W'(s);
      return s13 + NUMBER_W'(r);
   endfunction

endpackage

@@ hdl/cdpc_decode.sv @@
module cdpc_decode (
   input  logic [7:0]        rank_char,
   input  logic [7:0]        suit_char,
   output cdpc_pkg::card_type card
);
   import cdpc_pkg::*;

   logic     rank_ok;
   logic     suit_ok;
   rank_type rank_pos;
   suit_type suit_pos;

   // Rank character to its position in a23456789tjqk.
   always_comb begin
      rank_ok  = 1'b1;
      rank_pos = '0;
      case (rank_char)
         "a":     rank_pos = 4'd0;
         "2":     rank_pos = 4'd1;
         "3":     rank_pos = 4'd2;
         "4":     rank_pos = 4'd3;
         "5":     rank_pos = 4'd4;
         "6":     rank_pos = 4'd5;
         "7":     rank_pos = 4'd6;
         "8":     rank_pos = 4'd7;
         "9":     rank_pos = 4'd8;
         "t":     rank_pos = 4'd9;
         "j":     rank_pos = 4'd10;
         "q":     rank_pos = 4'd11;
         "k":     rank_pos = 4'd12;
         default: rank_ok  = 1'b0;
      endcase
   end

   // Suit character to its position in cdhs.
   always_comb begin
      suit_ok  = 1'b1;
      suit_pos = '0;
      case (suit_char)
         "c":     suit_pos = 2'd0;
         "d":     suit_pos = 2'd1;
         "h":     suit_pos = 2'd2;
         "s":     suit_pos = 2'd3;
         default: suit_ok  = 1'b0;
      endcase
   end

   assign card.ok   = rank_ok & suit_ok;
   assign card.rank = rank_pos;
   assign card.suit = suit_pos;

endmodule

@@ hdl/card_deck_permutation_checker.sv @@
// Channel | Direction | Ports                                        | Beat
// req     | in        | req_rank_char, req_suit_char, req_last_card | one card
// rsp     | out       | rsp_card_number, rsp_status, rsp_deck_done  | one verdict per card
//
// One card per clock while rsp does not stall: a beat is accepted in the cycle after
// the previous one. Each card reads its suit row of the seen memory on acceptance,
// tests and sets its bit in the test stage and loads the result register; a write from
// the card just before is forwarded. The verdict is offered from the result register.
// Reset and the last card of a deck clear the row valid bits, the count and the
// held error at once; no clearing pass. A stall on rsp holds the test stage.
module card_deck_permutation_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rank_char,
   input  logic [7:0] req_suit_char,
   input  logic       req_last_card,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_card_number,
   output logic [2:0] rsp_status,
   output logic       rsp_deck_done
);
   import cdpc_pkg::*;

   // Seen memory: one 13-bit row per suit, with a registered read.
   row_type seen_mem [SUIT_COUNT];
   row_type rdata_ff;

   logic [SUIT_COUNT-1:0] row_valid_ff, row_valid_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [ERROR_W-1:0]    error_ff, error_in;

   card_type dec_card;
   logic     accept;

   // Test stage registers.
   logic     s1_valid_ff, s1_valid_in;
   card_type s1_card_ff;
   logic     s1_last_ff;
   logic     s1_fwd_ff, s1_fwd_in;
   row_type  s1_fwd_row_ff;
   logic     s1_fire;

   row_type  row_cur;
   row_type  row_new;
   logic     dup;
   logic     mem_write;
   logic [COUNT_W-1:0]  count_step;
   logic [ERROR_W-1:0]  error_step;
   logic [STATUS_W-1:0] status_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NUMBER_W-1:0] rsp_number_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_done_ff;

   cdpc_decode u_decode (
      .rank_char (req_rank_char),
      .suit_char (req_suit_char),
      .card      (dec_card)
   );

   // Handshake: the test stage moves when the result register is free.
   assign s1_fire   = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | s1_fire;
   assign accept    = req_valid & req_ready;

   // Current row: forwarded write, stored row, or zero for a row of a past deck.
   always_comb begin
      if (s1_fwd_ff) begin
         row_cur = s1_fwd_row_ff;
      end else if (row_valid_ff[s1_card_ff.suit]) begin
         row_cur = rdata_ff;
      end else begin
         row_cur = '0;
      end
   end

   // Test and set of the card's bit.
   always_comb begin
      row_new   = row_cur | (RANK_COUNT'(1) << s1_card_ff.rank);
      dup       = s1_card_ff.ok & row_cur[s1_card_ff.rank];
      mem_write = s1_fire & s1_card_ff.ok & ~s1_last_ff;
      // A card read in the same cycle as this write sees the old row.
      s1_fwd_in = mem_write & accept & dec_card.ok & (dec_card.suit == s1_card_ff.suit);
   end

   // First error sticks; count saturates.
   always_comb begin
      error_step = error_ff;
      if (error_ff == ERR_NONE) begin
         if (!s1_card_ff.ok) begin
            error_step = ERR_INVALID;
         end else if (dup) begin
            error_step = ERR_DUP;
         end
      end
      count_step = (count_ff < COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
      if (s1_last_ff) begin
         if (count_step != COUNT_W'(CARDS_IN_DECK)) begin
            status_in = STATUS_WRONG_COUNT;
         end else if (error_step != ERR_NONE) begin
            status_in = STATUS_W'(error_step);
         end else begin
            status_in = STATUS_DECK_VALID;
         end
      end else begin
         status_in = STATUS_W'(error_step);
      end
   end

   // Next deck state; the last card clears everything.
   always_comb begin
      row_valid_in = row_valid_ff;
      count_in     = count_ff;
      error_in     = error_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            row_valid_in = '0;
            count_in     = '0;
            error_in     = ERR_NONE;
         end else begin
            count_in = count_step;
            error_in = error_step;
            if (s1_card_ff.ok) begin
               row_valid_in[s1_card_ff.suit] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      s1_valid_in = accept | (s1_valid_ff & ~s1_fire);
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         count_ff     <= '0;
         error_ff     <= ERR_NONE;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         count_ff     <= count_in;
         error_ff     <= error_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Test stage payload, loaded on acceptance.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_card_ff    <= dec_card;
         s1_last_ff    <= req_last_card;
         s1_fwd_ff     <= s1_fwd_in;
         s1_fwd_row_ff <= row_new;
      end
   end

   // Seen memory: write back from the test stage, read on acceptance.
   always_ff @(posedge clock) begin
      if (mem_write) begin
         seen_mem[s1_card_ff.suit] <= row_new;
      end
      if (accept) begin
         rdata_ff <= seen_mem[dec_card.suit];
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_number_ff <= s1_card_ff.ok ? deck_pos(s1_card_ff.suit, s1_card_ff.rank)
                                        : NO_CARD;
         rsp_status_ff <= status_in;
         rsp_done_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_card_number = rsp_number_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_deck_done   = rsp_done_ff;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import cdpc_pkg::*;

   // One card as driven on the request channel.
   typedef struct packed {
      logic [7:0] rank_char;
      logic [7:0] suit_char;
      logic       last_card;
   } card_beat_type;

   // One verdict as seen on the response channel.
   typedef struct packed {
      logic [NUMBER_W-1:0] card_number;
      logic [STATUS_W-1:0] status;
      logic                deck_done;
   } verdict_type;

   typedef enum int {
      DECK_CLEAN, DECK_DUP, DECK_BAD_CHAR, DECK_SHORT, DECK_LONG, DECK_NOISE
   } deck_kind_type;

   typedef enum int {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_mode_type;

   localparam int RANDOM_CARDS = 1750;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 10;

   logic       clock;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [7:0] req_rank_char   = 8'h00;
   logic [7:0] req_suit_char   = 8'h00;
   logic       req_last_card   = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;
   logic [5:0] rsp_card_number;
   logic [2:0] rsp_status;
   logic       rsp_deck_done;

   string rank_text = "a23456789tjqk";
   string suit_text = "cdhs";

   card_beat_type card_queue[$];
   verdict_type   verdict_queue[$];
   int            cards_planned   = 0;
   int            results_checked = 0;
   bit            check_failed    = 1'b0;
   logic          req_fire        = 1'b0;

   // Shadow of the deck state, updated on every accepted card.
   logic [CARDS_IN_DECK-1:0] deck_seen  = '0;
   logic [COUNT_W-1:0]       deck_count = '0;
   logic [ERROR_W-1:0]       deck_error = ERR_NONE;

   card_deck_permutation_checker DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rank_char   (req_rank_char),
      .req_suit_char   (req_suit_char),
      .req_last_card   (req_last_card),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_card_number (rsp_card_number),
      .rsp_status      (rsp_status),
      .rsp_deck_done   (rsp_deck_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** card_deck_permutation_checker: FAILED **");
      $finish;
   end

   // Position of a character in its list, or the list length when absent.
   function automatic int char_slot(input string set, input logic [7:0] ch);
      for (int i = 0; i < set.len(); i++) begin
         if (set[i] == ch) return i;
      end
      return set.len();
   endfunction

   function automatic logic [STATUS_W-1:0] status_of_error(input logic [ERROR_W-1:0] err);
      case (err)
         ERR_INVALID: return STATUS_INVALID;
         ERR_DUP:     return STATUS_DUP;
         default:     return STATUS_OK;
      endcase
   endfunction

   // Works out the verdict for one card and advances the shadow deck state.
   task automatic grade_card(input card_beat_type beat, output verdict_type verdict);
      int rank_pos;
      int suit_pos;
      int number;
      rank_pos = char_slot(rank_text, beat.rank_char);
      suit_pos = char_slot(suit_text, beat.suit_char);
      verdict.card_number = NO_CARD;
      if (rank_pos < RANK_COUNT && suit_pos < SUIT_COUNT) begin
         number = suit_pos * RANK_COUNT + rank_pos;
         verdict.card_number = NUMBER_W'(number);
         if (deck_seen[number] && deck_error == ERR_NONE) deck_error = ERR_DUP;
         deck_seen[number] = 1'b1;
      end else if (deck_error == ERR_NONE) begin
         deck_error = ERR_INVALID;
      end
      if (deck_count != COUNT_MAX) deck_count = deck_count + 1'b1;

      // The count check outranks any held error on the closing card.
      if (beat.last_card) begin
         if (deck_count != CARDS_IN_DECK) verdict.status = STATUS_WRONG_COUNT;
         else if (deck_error != ERR_NONE) verdict.status = status_of_error(deck_error);
         else verdict.status = STATUS_DECK_VALID;
      end else begin
         verdict.status = status_of_error(deck_error);
      end
      verdict.deck_done = beat.last_card;

      if (beat.last_card) begin
         deck_seen  = '0;
         deck_count = '0;
         deck_error = ERR_NONE;
      end
   endtask

   function automatic card_beat_type card_of(input int number);
      card_beat_type beat;
      beat.rank_char = rank_text[number % RANK_COUNT];
      beat.suit_char = suit_text[number / RANK_COUNT];
      beat.last_card = 1'b0;
      return beat;
   endfunction

   // A byte outside the given list: often a list character less 20h (uppercase for a letter), else any byte.
   function automatic logic [7:0] stray_char(input string set);
      logic [7:0] ch;
      do begin
         if ($urandom_range(0, 1) == 1) ch = set[$urandom_range(0, set.len() - 1)] - 8'h20;
         else ch = 8'($urandom_range(0, 255));
      end while (char_slot(set, ch) != set.len());
      return ch;
   endfunction

   function automatic card_beat_type spoiled(input card_beat_type beat);
      card_beat_type bad;
      bad = beat;
      case ($urandom_range(0, 2))
         0: bad.rank_char = stray_char(rank_text);
         1: bad.suit_char = stray_char(suit_text);
         default: begin
            bad.rank_char = stray_char(rank_text);
            bad.suit_char = stray_char(suit_text);
         end
      endcase
      return bad;
   endfunction

   task automatic push_card(input logic [7:0] rank_ch, input logic [7:0] suit_ch,
                            input logic last);
      card_beat_type beat;
      beat.rank_char = rank_ch;
      beat.suit_char = suit_ch;
      beat.last_card = last;
      card_queue.insert(card_queue.size(), beat);
      cards_planned++;
   endtask

   // Builds one deck: mostly a shuffled full deck, some of them damaged.
   task automatic add_deck();
      card_beat_type deck[$];
      card_beat_type beat;
      card_beat_type held;
      deck_kind_type kind;
      int pick;
      int i;
      int j;
      int extra;
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = DECK_CLEAN;
      else if (pick < 52) kind = DECK_DUP;
      else if (pick < 64) kind = DECK_BAD_CHAR;
      else if (pick < 74) kind = DECK_SHORT;
      else if (pick < 84) kind = DECK_LONG;
      else kind = DECK_NOISE;

      if (kind == DECK_NOISE) begin
         extra = $urandom_range(1, 10);
         for (i = 0; i < extra; i++) begin
            if ($urandom_range(0, 1) == 1) begin
               beat = card_of($urandom_range(0, CARDS_IN_DECK - 1));
            end else begin
               beat.rank_char = 8'($urandom_range(0, 255));
               beat.suit_char = 8'($urandom_range(0, 255));
               beat.last_card = 1'b0;
            end
            deck.insert(deck.size(), beat);
         end
      end else begin
         for (i = 0; i < CARDS_IN_DECK; i++) deck.insert(deck.size(), card_of(i));
         for (i = CARDS_IN_DECK - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            held = deck[i];
            deck[i] = deck[j];
            deck[j] = held;
         end
         case (kind)
            DECK_DUP: begin
               j = $urandom_range(0, CARDS_IN_DECK - 1);
               i = (j + $urandom_range(1, CARDS_IN_DECK - 1)) % CARDS_IN_DECK;
               deck[i] = deck[j];
               if ($urandom_range(0, 2) == 0) begin
                  j = $urandom_range(0, CARDS_IN_DECK - 1);
                  deck[j] = spoiled(deck[j]);
               end
            end
            DECK_BAD_CHAR: begin
               extra = $urandom_range(1, 3);
               repeat (extra) begin
                  j = $urandom_range(0, CARDS_IN_DECK - 1);
                  deck[j] = spoiled(deck[j]);
               end
            end
            DECK_SHORT: begin
               extra = $urandom_range(1, 4);
               repeat (extra) deck.delete($urandom_range(0, deck.size() - 1));
               if ($urandom_range(0, 1) == 1) begin
                  j = $urandom_range(0, deck.size() - 1);
                  deck[j] = spoiled(deck[j]);
               end
            end
            DECK_LONG: begin
               // Twelve or more extra cards drive the count into saturation.
               extra = $urandom_range(1, 20);
               repeat (extra) begin
                  beat = card_of($urandom_range(0, CARDS_IN_DECK - 1));
                  if ($urandom_range(0, 3) == 0) beat = spoiled(beat);
                  deck.insert(deck.size(), beat);
               end
            end
            default: ;
         endcase
      end

      deck[deck.size() - 1].last_card = 1'b1;
      foreach (deck[k]) card_queue.insert(card_queue.size(), deck[k]);
      cards_planned += deck.size();
   endtask

   // Stimulus: a directed opening, then random decks, then the drain.
   initial begin
      // Extreme bytes, uppercase letters and a duplicate behind an invalid card.
      push_card("a", "c", 1'b0);
      push_card("k", "s", 1'b0);
      push_card(8'h00, "d", 1'b0);
      push_card("A", "c", 1'b0);
      push_card("k", "s", 1'b0);
      push_card(8'hFF, 8'hFF, 1'b1);
      // Duplicate first, then an invalid suit: the duplicate stays held.
      push_card("2", "h", 1'b0);
      push_card("2", "h", 1'b0);
      push_card("3", "S", 1'b0);
      push_card("t", "d", 1'b1);
      // A deck of one card.
      push_card("q", "c", 1'b1);
      // Every rank, spread over every suit.
      for (int i = 0; i < RANK_COUNT; i++) begin
         push_card(rank_text[i], suit_text[i % SUIT_COUNT], i == RANK_COUNT - 1);
      end
      while (cards_planned < 24 + RANDOM_CARDS) add_deck();

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      while (card_queue.size() != 0 || req_valid) @(posedge clock);
      while (verdict_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (!check_failed) begin
         $display("** card_deck_permutation_checker: PASSED **");
      end else begin
         $display("** card_deck_permutation_checker: FAILED **");
      end
      $finish;
   end

   // Sender: bursts of beats with random gaps between them.
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin : sender
      card_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (card_queue.size() > 0) begin
            beat = card_queue.pop_front();
            req_valid     <= 1'b1;
            req_rank_char <= beat.rank_char;
            req_suit_char <= beat.suit_char;
            req_last_card <= beat.last_card;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern changes mode now and then, with one long hold-off.
   rx_mode_type rx_mode   = RX_STEADY;
   int          mode_left = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_checked >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 300);
         end else begin
            mode_left--;
         end
         case (rx_mode)
            RX_STEADY: rsp_ready <= 1'b1;
            RX_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
            default:   rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Monitor: predicts on every accepted card and checks every verdict beat.
   always @(posedge clock) begin : monitor
      card_beat_type beat;
      verdict_type   want;
      verdict_type   got;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            beat.rank_char = req_rank_char;
            beat.suit_char = req_suit_char;
            beat.last_card = req_last_card;
            grade_card(beat, want);
            verdict_queue.insert(verdict_queue.size(), want);
         end
         if (rsp_valid && rsp_ready) begin
            got.card_number = rsp_card_number;
            got.status      = rsp_status;
            got.deck_done   = rsp_deck_done;
            results_checked++;
            if (verdict_queue.size() == 0) begin
               $display("%0t: verdict beat with none expected: number %0d status %0d done %0d",
                        $time, got.card_number, got.status, got.deck_done);
               check_failed = 1'b1;
            end else begin
               want = verdict_queue.pop_front();
               if (got.card_number !== want.card_number) begin
                  $display("%0t: card_number expected %0d actual %0d",
                           $time, want.card_number, got.card_number);
                  check_failed = 1'b1;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  check_failed = 1'b1;
               end
               if (got.deck_done !== want.deck_done) begin
                  $display("%0t: deck_done expected %0d actual %0d",
                           $time, want.deck_done, got.deck_done);
                  check_failed = 1'b1;
               end
            end
         end
      end
   end

endmodule

@@ sim.f @@
hdl/cdpc_pkg.sv
hdl/cdpc_decode.sv
hdl/card_deck_permutation_checker.sv
tb/tb_top.sv
